### rtl/tgcr_pkg.sv
// Shared types, constants and the 5x8 font table for the text glyph column renderer.
// No dependencies; imported by tgcr_cursor and the top level.
package tgcr_pkg;

  localparam int unsigned GLYPH_WIDTH_DEF     = 5;
  localparam int unsigned DISPLAY_COLUMNS_DEF = 128;
  localparam int unsigned TEXT_LINES_DEF      = 8;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;

  localparam logic [7:0] NewlineCode = 8'h0A;
  localparam logic [7:0] FontFirst   = 8'h20;
  localparam logic [7:0] FontCount   = 8'd95;
  localparam logic [3:0] FontCols    = 4'd5;

  typedef struct packed {
    logic       has_cmd;
    logic [2:0] cmd_page;
    logic [6:0] cmd_col;
    logic       draw;
    logic [7:0] code;
  } plan_t;

  localparam logic [7:0] FONT_ROM [95][5] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h2f,8'h00,8'h00},
    '{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h7f,8'h14,8'h7f,8'h14},
    '{8'h24,8'h2a,8'h7f,8'h2a,8'h12}, '{8'h23,8'h13,8'h08,8'h64,8'h62},
    '{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
    '{8'h00,8'h1c,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1c,8'h00},
    '{8'h14,8'h08,8'h3E,8'h08,8'h14}, '{8'h08,8'h08,8'h3E,8'h08,8'h08},
    '{8'h00,8'h00,8'hA0,8'h60,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
    '{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
    '{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
    '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4B,8'h31},
    '{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
    '{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
    '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
    '{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
    '{8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
    '{8'h00,8'h41,8'h22,8'h14,8'h08}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
    '{8'h32,8'h49,8'h59,8'h51,8'h3E},
    '{8'h7C,8'h12,8'h11,8'h12,8'h7C}, '{8'h7F,8'h49,8'h49,8'h49,8'h36},
    '{8'h3E,8'h41,8'h41,8'h41,8'h22}, '{8'h7F,8'h41,8'h41,8'h22,8'h1C},
    '{8'h7F,8'h49,8'h49,8'h49,8'h41}, '{8'h7F,8'h09,8'h09,8'h09,8'h01},
    '{8'h3E,8'h41,8'h49,8'h49,8'h7A}, '{8'h7F,8'h08,8'h08,8'h08,8'h7F},
    '{8'h00,8'h41,8'h7F,8'h41,8'h00}, '{8'h20,8'h40,8'h41,8'h3F,8'h01},
    '{8'h7F,8'h08,8'h14,8'h22,8'h41}, '{8'h7F,8'h40,8'h40,8'h40,8'h40},
    '{8'h7F,8'h02,8'h0C,8'h02,8'h7F}, '{8'h7F,8'h04,8'h08,8'h10,8'h7F},
    '{8'h3E,8'h41,8'h41,8'h41,8'h3E}, '{8'h7F,8'h09,8'h09,8'h09,8'h06},
    '{8'h3E,8'h41,8'h51,8'h21,8'h5E}, '{8'h7F,8'h09,8'h19,8'h29,8'h46},
    '{8'h46,8'h49,8'h49,8'h49,8'h31}, '{8'h01,8'h01,8'h7F,8'h01,8'h01},
    '{8'h3F,8'h40,8'h40,8'h40,8'h3F}, '{8'h1F,8'h20,8'h40,8'h20,8'h1F},
    '{8'h3F,8'h40,8'h38,8'h40,8'h3F}, '{8'h63,8'h14,8'h08,8'h14,8'h63},
    '{8'h07,8'h08,8'h70,8'h08,8'h07}, '{8'h61,8'h51,8'h49,8'h45,8'h43},
    '{8'h00,8'h7F,8'h41,8'h41,8'h00}, '{8'h55,8'hAA,8'h55,8'hAA,8'h55},
    '{8'h00,8'h41,8'h41,8'h7F,8'h00}, '{8'h04,8'h02,8'h01,8'h02,8'h04},
    '{8'h40,8'h40,8'h40,8'h40,8'h40}, '{8'h00,8'h03,8'h05,8'h00,8'h00},
    '{8'h20,8'h54,8'h54,8'h54,8'h78}, '{8'h7F,8'h48,8'h44,8'h44,8'h38},
    '{8'h38,8'h44,8'h44,8'h44,8'h20}, '{8'h38,8'h44,8'h44,8'h48,8'h7F},
    '{8'h38,8'h54,8'h54,8'h54,8'h18}, '{8'h08,8'h7E,8'h09,8'h01,8'h02},
    '{8'h18,8'hA4,8'hA4,8'hA4,8'h7C}, '{8'h7F,8'h08,8'h04,8'h04,8'h78},
    '{8'h00,8'h44,8'h7D,8'h40,8'h00}, '{8'h40,8'h80,8'h84,8'h7D,8'h00},
    '{8'h7F,8'h10,8'h28,8'h44,8'h00}, '{8'h00,8'h41,8'h7F,8'h40,8'h00},
    '{8'h7C,8'h04,8'h18,8'h04,8'h78}, '{8'h7C,8'h08,8'h04,8'h04,8'h78},
    '{8'h38,8'h44,8'h44,8'h44,8'h38}, '{8'hFC,8'h24,8'h24,8'h24,8'h18},
    '{8'h18,8'h24,8'h24,8'h18,8'hFC}, '{8'h7C,8'h08,8'h04,8'h04,8'h08},
    '{8'h48,8'h54,8'h54,8'h54,8'h20}, '{8'h04,8'h3F,8'h44,8'h40,8'h20},
    '{8'h3C,8'h40,8'h40,8'h20,8'h7C}, '{8'h1C,8'h20,8'h40,8'h20,8'h1C},
    '{8'h3C,8'h40,8'h30,8'h40,8'h3C}, '{8'h44,8'h28,8'h10,8'h28,8'h44},
    '{8'h1C,8'hA0,8'hA0,8'hA0,8'h7C}, '{8'h44,8'h64,8'h54,8'h4C,8'h44},
    '{8'h00,8'h10,8'h7C,8'h82,8'h00}, '{8'h00,8'h00,8'hFF,8'h00,8'h00},
    '{8'h00,8'h82,8'h7C,8'h10,8'h00}, '{8'h00,8'h06,8'h09,8'h09,8'h06}
  };

  // blank outside the printable range and past the font's last column
  function automatic logic [7:0] font_column(input logic [7:0] code, input logic [3:0] col);
    logic [7:0] idx;
    logic [7:0] res;
    idx = code - FontFirst;
    res = 8'h00;
    if (code >= FontFirst && idx < FontCount && col < FontCols) begin
      res = FONT_ROM[idx[6:0]][col[2:0]];
    end
    return res;
  endfunction

endpackage

### rtl/tgcr_cursor.sv
// Cursor and line state of the text glyph column renderer; plans the results of each request.
// Depends on tgcr_pkg.
module tgcr_cursor #(
  parameter int unsigned GLYPH_WIDTH     = tgcr_pkg::GLYPH_WIDTH_DEF,
  parameter int unsigned DISPLAY_COLUMNS = tgcr_pkg::DISPLAY_COLUMNS_DEF,
  parameter int unsigned TEXT_LINES      = tgcr_pkg::TEXT_LINES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  logic            kind_i,
  input  logic [7:0]      char_code_i,
  input  logic [7:0]      page_req_i,
  input  logic [7:0]      column_req_i,
  output tgcr_pkg::plan_t plan_o,
  output logic            emit_o
);
  import tgcr_pkg::*;

  localparam int unsigned LineW = $clog2(TEXT_LINES);

  logic [LineW-1:0] line_q, line_d, line_next;
  logic [7:0]       cursor_q, cursor_d, cursor_base;
  logic [7:0]       line8;
  logic             wrap, newline, setpos_ok;

  always_comb begin
    wrap      = ({2'b00, cursor_q} + 10'(GLYPH_WIDTH)) >= 10'(DISPLAY_COLUMNS);
    newline   = (char_code_i == NewlineCode);
    setpos_ok = (page_req_i <= 8'(TEXT_LINES - 1)) && (column_req_i <= 8'(DISPLAY_COLUMNS - 1));
    line_next = (line_q == LineW'(TEXT_LINES - 1)) ? '0 : line_q + LineW'(1);
    line8     = 8'(line_next);
    cursor_base = wrap ? 8'h00 : cursor_q;

    line_d   = line_q;
    cursor_d = cursor_q;
    plan_o   = '0;
    plan_o.code = char_code_i;

    if (kind_i) begin
      if (setpos_ok) begin
        line_d          = LineW'(page_req_i);
        cursor_d        = column_req_i;
        plan_o.has_cmd  = 1'b1;
        plan_o.cmd_page = page_req_i[2:0];
        plan_o.cmd_col  = column_req_i[6:0];
      end
    end else begin
      if (wrap || newline) begin
        line_d          = line_next;
        plan_o.has_cmd  = 1'b1;
        plan_o.cmd_page = line8[2:0];
      end
      if (newline) begin
        cursor_d = 8'h00;
      end else begin
        plan_o.draw = 1'b1;
        cursor_d    = cursor_base + 8'(GLYPH_WIDTH + 1);
      end
    end
    emit_o = plan_o.has_cmd | plan_o.draw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q   <= '0;
      cursor_q <= '0;
    end else if (take_i) begin
      line_q   <= line_d;
      cursor_q <= cursor_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(line_q) < TEXT_LINES)
    else $error("line out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && !kind_i && !newline |=> cursor_q != $past(cursor_base))
    else $error("cursor did not advance after a glyph");

endmodule

### rtl/text_glyph_column_renderer_core.sv
// Text glyph column renderer: one request in, position commands and column bytes out.
// Depends on tgcr_pkg and tgcr_cursor.
//
// A character request yields GLYPH_WIDTH font columns and a blank spacer byte, preceded by a
// position command when the glyph would reach the right edge; a newline yields a position
// command alone, a valid set-position request one command and an invalid one nothing. The
// result channel moves one byte per cycle, while the sink is ready, through a single output
// register, and an invalid set position is taken with no result. The next request is taken
// in the cycle that the current one hands over its last byte.
module text_glyph_column_renderer_core #(
  parameter int unsigned GLYPH_WIDTH     = tgcr_pkg::GLYPH_WIDTH_DEF,
  parameter int unsigned DISPLAY_COLUMNS = tgcr_pkg::DISPLAY_COLUMNS_DEF,
  parameter int unsigned TEXT_LINES      = tgcr_pkg::TEXT_LINES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // char_code[7:0], page_req[15:8], column_req[23:16]
  input  logic [tgcr_pkg::InDataW-1:0]  s_axis_tdata,
  // kind
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // column_bits[7:0], page_out[10:8], column_out[17:11], zero[23:18]
  output logic [tgcr_pkg::OutDataW-1:0] m_axis_tdata,
  // out_kind
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast
);
  import tgcr_pkg::*;

  localparam int unsigned StepW = $clog2(GLYPH_WIDTH + 3);

  plan_t            plan, work_q;
  logic             emit, take, advance, last_step;
  logic             work_v_q;
  logic [StepW-1:0] step_q, total, data_idx;
  logic             res_cmd;
  logic [7:0]       res_bits;

  logic                out_v_q;
  logic [OutDataW-1:0] out_data_q;
  logic                out_kind_q, out_last_q;

  tgcr_cursor #(
    .GLYPH_WIDTH    (GLYPH_WIDTH),
    .DISPLAY_COLUMNS(DISPLAY_COLUMNS),
    .TEXT_LINES     (TEXT_LINES)
  ) u_cursor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .kind_i      (s_axis_tuser),
    .char_code_i (s_axis_tdata[7:0]),
    .page_req_i  (s_axis_tdata[15:8]),
    .column_req_i(s_axis_tdata[23:16]),
    .plan_o      (plan),
    .emit_o      (emit)
  );

  always_comb begin
    total     = StepW'(work_q.has_cmd) + (work_q.draw ? StepW'(GLYPH_WIDTH + 1) : '0);
    last_step = (step_q == total - StepW'(1));
    advance   = work_v_q && (!out_v_q || m_axis_tready);
    s_axis_tready = !work_v_q || (advance && last_step);
    take      = s_axis_tvalid && s_axis_tready;
    res_cmd   = work_q.has_cmd && (step_q == '0);
    data_idx  = step_q - StepW'(work_q.has_cmd);
    res_bits  = 8'h00;
    if (!res_cmd && data_idx < StepW'(GLYPH_WIDTH)) begin
      res_bits = font_column(work_q.code, 4'(data_idx));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_v_q <= 1'b0;
      step_q   <= '0;
    end else if (take) begin
      work_v_q <= emit;
      step_q   <= '0;
    end else if (advance) begin
      work_v_q <= !last_step;
      step_q   <= step_q + StepW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      work_q <= plan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_kind_q <= res_cmd;
      out_last_q <= last_step;
      out_data_q <= res_cmd ? {6'b0, work_q.cmd_col, work_q.cmd_page, 8'h00}
                            : {16'b0, res_bits};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_v_q |-> step_q < total)
    else $error("step counter past the end of the request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] == 8'h00)
    else $error("position command carries pixel data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && emit |=> work_v_q && step_q == '0)
    else $error("request with results not loaded");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser && m_axis_tlast |-> m_axis_tdata[7:0] == 8'h00)
    else $error("last data byte is not the spacer");

endmodule

### sim/testbench.sv
// Testbench for text_glyph_column_renderer_core: random and directed text requests are
// checked byte by byte against an in-bench character generator with its own font table.
// Depends on tgcr_pkg and the renderer RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int GlyphW        = tgcr_pkg::GLYPH_WIDTH_DEF;
  localparam int DisplayCols   = tgcr_pkg::DISPLAY_COLUMNS_DEF;
  localparam int TextLines     = tgcr_pkg::TEXT_LINES_DEF;
  localparam int RandomCount   = 330;
  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 16;
  localparam int ReportMax     = 10;

  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_SETPOS = 1'b1;
  localparam logic OUT_DATA    = 1'b0;
  localparam logic OUT_CMD     = 1'b1;

  // five columns per glyph, first column in the top byte, codes 0x20 to 0x7E
  localparam logic [39:0] FONT_STRIPS [95] = '{
    40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
    40'h14083e0814, 40'h08083e0808, 40'h0000a06000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503, 40'h3649494936,
    40'h064949291e, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324959513e, 40'h7c1211127c, 40'h7f49494936,
    40'h3e41414122, 40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
    40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906, 40'h3e4151215e,
    40'h7f09192946, 40'h4649494931, 40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f,
    40'h3f4038403f, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h55aa55aa55, 40'h0041417f00, 40'h0402010204, 40'h4040404040, 40'h0003050000,
    40'h2054545478, 40'h7f48444438, 40'h3844444420, 40'h384444487f, 40'h3854545418,
    40'h087e090102, 40'h18a4a4a47c, 40'h7f08040478, 40'h00447d4000, 40'h4080847d00,
    40'h7f10284400, 40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
    40'hfc24242418, 40'h18242418fc, 40'h7c08040408, 40'h4854545420, 40'h043f444020,
    40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c, 40'h4428102844, 40'h1ca0a0a07c,
    40'h4464544c44, 40'h00107c8200, 40'h0000ff0000, 40'h00827c1000, 40'h0006090906
  };

  typedef struct packed {
    logic        kind;
    logic [7:0]  code;
    logic [7:0]  page;
    logic [7:0]  col;
    int unsigned gap;
    bit          drain;
  } text_request_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] bits;
    logic [2:0] page;
    logic [6:0] col;
    logic       last;
  } display_byte_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [tgcr_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                          s_axis_tuser = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [tgcr_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          m_axis_tuser;
  logic                          m_axis_tlast;

  text_request_t request_q [$];
  display_byte_t display_bytes_q [$];
  text_request_t cur_req;
  bit            have_req;
  int unsigned   gap_left;
  bit            send_steady;
  bit            sink_steady;
  int unsigned   stall_left;
  int unsigned   quiet_cycles;

  logic [2:0] text_line;
  logic [7:0] cursor_col;

  int n_requests;
  int n_bytes;
  int n_wraps;
  int n_newlines;
  int n_ignored;
  int n_errors;

  text_glyph_column_renderer_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [7:0] glyph_column(input logic [7:0] code, input int idx);
    logic [39:0] strip;
    if (code < 8'h20 || code > 8'h7e || idx >= 5) return 8'h00;
    strip = FONT_STRIPS[code - 8'h20];
    return strip[39 - 8 * idx -: 8];
  endfunction

  // work out every byte that one accepted request must produce
  function automatic void render_request(input text_request_t r);
    display_byte_t burst [8];
    int n;
    n = 0;
    if (r.kind == KIND_SETPOS) begin
      if (r.page <= TextLines - 1 && r.col <= DisplayCols - 1) begin
        text_line  = r.page[2:0];
        cursor_col = r.col;
        burst[n] = '{kind: OUT_CMD, bits: 8'h00, page: r.page[2:0], col: r.col[6:0], last: 1'b0};
        n++;
      end else begin
        n_ignored++;
      end
    end else begin
      if (int'(cursor_col) + GlyphW >= DisplayCols || r.code == tgcr_pkg::NewlineCode) begin
        if (r.code == tgcr_pkg::NewlineCode) n_newlines++;
        else n_wraps++;
        text_line  = 3'((int'(text_line) + 1) % TextLines);
        cursor_col = 8'h00;
        burst[n] = '{kind: OUT_CMD, bits: 8'h00, page: text_line, col: 7'd0, last: 1'b0};
        n++;
      end
      if (r.code != tgcr_pkg::NewlineCode) begin
        for (int i = 0; i <= GlyphW; i++) begin
          burst[n] = '{kind: OUT_DATA, bits: (i < GlyphW) ? glyph_column(r.code, i) : 8'h00,
                       page: 3'd0, col: 7'd0, last: 1'b0};
          n++;
          cursor_col = cursor_col + 8'd1;
        end
      end
    end
    if (n > 0) burst[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) display_bytes_q.push_back(burst[i]);
  endfunction

  function automatic void add_request(input logic kind, input logic [7:0] code,
                                      input logic [7:0] page, input logic [7:0] col,
                                      input bit drain);
    text_request_t r;
    if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
    r.kind  = kind;
    r.code  = code;
    r.page  = page;
    r.col   = col;
    r.gap   = send_steady ? 0 : $urandom_range(0, 4);
    r.drain = drain;
    request_q.push_back(r);
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly printable text and valid moves, some newlines, odd codes and bad moves
  function automatic bit add_random_request(input bit drain);
    int pick;
    logic [7:0] page;
    logic [7:0] col;
    pick = $urandom_range(0, 99);
    if (pick < 66) begin
      add_request(KIND_DRAW, 8'($urandom_range(8'h20, 8'h7e)), any_byte(), any_byte(), drain);
    end else if (pick < 72) begin
      add_request(KIND_DRAW, tgcr_pkg::NewlineCode, any_byte(), any_byte(), drain);
    end else if (pick < 80) begin
      add_request(KIND_DRAW, any_byte(), any_byte(), any_byte(), drain);
    end else if (pick < 92) begin
      page = 8'($urandom_range(0, TextLines - 1));
      col  = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(DisplayCols - 12, DisplayCols - 1))
                                         : 8'($urandom_range(0, DisplayCols - 1));
      add_request(KIND_SETPOS, any_byte(), page, col, drain);
    end else begin
      page = any_byte();
      col  = any_byte();
      if ($urandom_range(0, 1) == 1) page = 8'($urandom_range(TextLines, 255));
      else col = 8'($urandom_range(DisplayCols, 255));
      add_request(KIND_SETPOS, any_byte(), page, col, drain);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      have_req   = 1'b0;
      gap_left   = 0;
      text_line  = 3'd0;
      cursor_col = 8'h00;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        render_request(cur_req);
        n_requests++;
        have_req = 1'b0;
      end
      if (!have_req && request_q.size() != 0) begin
        cur_req  = request_q.pop_front();
        have_req = 1'b1;
        gap_left = cur_req.gap;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the request until taken
      end else if (have_req && gap_left == 0 &&
                   !(cur_req.drain && display_bytes_q.size() != 0)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cur_req.col, cur_req.page, cur_req.code};
        s_axis_tuser  <= cur_req.kind;
      end else begin
        s_axis_tvalid <= 1'b0;
        if (have_req && gap_left > 0) gap_left--;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    display_byte_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_bytes++;
        if (display_bytes_q.size() == 0) begin
          n_errors++;
          if (n_errors <= ReportMax)
            $display("unexpected byte: kind %0b tdata %h last %0b",
                     m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end else begin
          want = display_bytes_q.pop_front();
          if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.bits ||
              m_axis_tdata[10:8] !== want.page || m_axis_tdata[17:11] !== want.col ||
              m_axis_tdata[23:18] !== 6'd0 || m_axis_tlast !== want.last) begin
            n_errors++;
            if (n_errors <= ReportMax)
              $display("byte %0d: expected kind %0b bits %h page %0d col %0d last %0b, got kind %0b bits %h page %0d col %0d pad %h last %0b",
                       n_bytes, want.kind, want.bits, want.page, want.col, want.last,
                       m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[10:8],
                       m_axis_tdata[17:11], m_axis_tdata[23:18], m_axis_tlast);
          end
        end
        if ($urandom_range(0, 47) == 0) sink_steady = !sink_steady;
        stall_left = sink_steady ? 0 : $urandom_range(0, 4);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WatchdogLimit) begin
        $display("text_glyph_column_renderer_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int counted;
    send_steady = 1'b0;
    sink_steady = 1'b0;
    // moves: valid corners, page and column out of range
    add_request(KIND_SETPOS, 8'h00, 8'd0, 8'd0, 1'b0);
    add_request(KIND_SETPOS, 8'hff, 8'd7, 8'd127, 1'b0);
    add_request(KIND_DRAW, 8'h41, 8'h00, 8'h00, 1'b0);
    add_request(KIND_SETPOS, 8'h00, 8'd8, 8'd0, 1'b0);
    add_request(KIND_SETPOS, 8'h00, 8'd0, 8'd128, 1'b0);
    add_request(KIND_SETPOS, 8'hff, 8'hff, 8'hff, 1'b0);
    // font edges and codes outside it
    add_request(KIND_DRAW, 8'h20, 8'hff, 8'hff, 1'b0);
    add_request(KIND_DRAW, 8'h7e, 8'h00, 8'h00, 1'b0);
    add_request(KIND_DRAW, 8'h1f, 8'h00, 8'h00, 1'b0);
    add_request(KIND_DRAW, 8'h7f, 8'h00, 8'h00, 1'b0);
    add_request(KIND_DRAW, 8'h00, 8'h00, 8'h00, 1'b0);
    add_request(KIND_DRAW, 8'hff, 8'h00, 8'h00, 1'b0);
    add_request(KIND_DRAW, tgcr_pkg::NewlineCode, 8'h00, 8'h00, 1'b0);
    // right edge: just fits, then must wrap, then wrap off the bottom line
    add_request(KIND_SETPOS, 8'h00, 8'd3, 8'd122, 1'b0);
    add_request(KIND_DRAW, 8'h57, 8'h00, 8'h00, 1'b0);
    add_request(KIND_SETPOS, 8'h00, 8'd3, 8'd123, 1'b0);
    add_request(KIND_DRAW, 8'h5c, 8'h00, 8'h00, 1'b0);
    add_request(KIND_SETPOS, 8'h00, 8'd7, 8'd123, 1'b0);
    add_request(KIND_DRAW, 8'h7c, 8'h00, 8'h00, 1'b0);
    add_request(KIND_SETPOS, 8'h00, 8'd7, 8'd0, 1'b0);
    add_request(KIND_DRAW, tgcr_pkg::NewlineCode, 8'h00, 8'h00, 1'b0);
    add_request(KIND_DRAW, 8'h67, 8'h00, 8'h00, 1'b0);
    counted = 0;
    if (add_random_request(1'b1)) counted++;
    while (counted < RandomCount)
      if (add_random_request($urandom_range(0, 59) == 0)) counted++;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (request_q.size() != 0 || have_req || s_axis_tvalid || display_bytes_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (display_bytes_q.size() != 0) n_errors++;

    $display("ran %0d requests: %0d edge wraps, %0d newlines, %0d rejected moves",
             n_requests, n_wraps, n_newlines, n_ignored);
    $display("checked %0d output bytes, %0d failures", n_bytes, n_errors);
    if (n_errors == 0) begin
      $display("text_glyph_column_renderer_core: match");
    end else begin
      $display("text_glyph_column_renderer_core: mismatch");
    end
    $finish;
  end

endmodule
